### hdl/binary_to_decimal_ascii_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the decimal converter checkers.
// ----------------------------------------------------------------------------
`ifndef BINARY_TO_DECIMAL_ASCII_CORE_MACROS_SVH
`define BINARY_TO_DECIMAL_ASCII_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define B2DA_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define B2DA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/b2da_pkg.sv
// ----------------------------------------------------------------------------
// Binary to decimal ASCII package
// Constants, control word layout and microcode table of the converter.
// ----------------------------------------------------------------------------
package b2da_pkg;

  localparam int unsigned VALUE_WIDTH_DEF = 32;
  localparam int unsigned MAX_DIGITS_DEF  = 10;
  localparam int unsigned DIGIT_W         = 4;
  localparam int unsigned ASCII_W         = 6;
  localparam logic [ASCII_W-1:0] ASCII_ZERO = 6'd48;
  localparam logic [DIGIT_W-1:0] DABBLE_LIMIT = 4'd5;
  localparam logic [DIGIT_W-1:0] DABBLE_ADD   = 4'd3;

  localparam int unsigned NUM_STEPS = 4;
  localparam int unsigned STEP_W    = $clog2(NUM_STEPS);

  localparam logic [STEP_W-1:0] STEP_LOAD   = 2'd0;
  localparam logic [STEP_W-1:0] STEP_DABBLE = 2'd1;
  localparam logic [STEP_W-1:0] STEP_SKIP   = 2'd2;
  localparam logic [STEP_W-1:0] STEP_EMIT   = 2'd3;

  typedef enum logic [1:0] {
    ACT_LOAD,
    ACT_DABBLE,
    ACT_SKIP,
    ACT_EMIT
  } act_e;

  typedef enum logic [1:0] {
    COND_NEVER,
    COND_BITS_LEFT,
    COND_LEAD_ZERO,
    COND_MORE_DIGITS
  } cond_e;

  typedef struct packed {
    act_e              act;
    cond_e             cond;
    logic [STEP_W-1:0] target;
  } ucode_t;

  typedef struct packed {
    logic in_valid;
    logic out_free;
    logic bits_left;
    logic lead_zero;
    logic more_digits;
  } status_t;

  typedef struct packed {
    logic in_ready;
    logic load;
    logic dabble;
    logic skip;
    logic emit;
  } ctrl_t;

  // The emit step falls through to the load step when the step counter wraps.
  function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] step);
    ucode_t word;
    case (step)
      STEP_LOAD:   word = '{act: ACT_LOAD,   cond: COND_NEVER,       target: STEP_LOAD};
      STEP_DABBLE: word = '{act: ACT_DABBLE, cond: COND_BITS_LEFT,   target: STEP_DABBLE};
      STEP_SKIP:   word = '{act: ACT_SKIP,   cond: COND_LEAD_ZERO,   target: STEP_SKIP};
      STEP_EMIT:   word = '{act: ACT_EMIT,   cond: COND_MORE_DIGITS, target: STEP_EMIT};
      default:     word = '{act: ACT_LOAD,   cond: COND_NEVER,       target: STEP_LOAD};
    endcase
    return word;
  endfunction

endpackage

### hdl/b2da_seq.sv
// ----------------------------------------------------------------------------
// Microcode sequencer
// Step counter over the control store, with holds and conditional jumps.
// ----------------------------------------------------------------------------
module b2da_seq (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  b2da_pkg::status_t status_i,
  output b2da_pkg::ctrl_t   ctrl_o
);

  logic [b2da_pkg::STEP_W-1:0] step_q;
  logic [b2da_pkg::STEP_W-1:0] step_d;
  b2da_pkg::ucode_t            word;
  logic                        hold;
  logic                        cond_true;

  always_comb begin
    word = b2da_pkg::ucode_rom(step_q);

    case (word.cond)
      b2da_pkg::COND_NEVER:       cond_true = 1'b0;
      b2da_pkg::COND_BITS_LEFT:   cond_true = status_i.bits_left;
      b2da_pkg::COND_LEAD_ZERO:   cond_true = status_i.lead_zero;
      b2da_pkg::COND_MORE_DIGITS: cond_true = status_i.more_digits;
      default:                    cond_true = 1'b0;
    endcase

    hold = ((word.act == b2da_pkg::ACT_LOAD) && !status_i.in_valid) ||
           ((word.act == b2da_pkg::ACT_EMIT) && !status_i.out_free);

    ctrl_o.in_ready = (word.act == b2da_pkg::ACT_LOAD);
    ctrl_o.load     = (word.act == b2da_pkg::ACT_LOAD) && status_i.in_valid;
    ctrl_o.dabble   = (word.act == b2da_pkg::ACT_DABBLE);
    ctrl_o.skip     = (word.act == b2da_pkg::ACT_SKIP) && status_i.lead_zero;
    ctrl_o.emit     = (word.act == b2da_pkg::ACT_EMIT) && status_i.out_free;

    if (hold) begin
      step_d = step_q;
    end else if (cond_true) begin
      step_d = word.target;
    end else begin
      step_d = step_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= b2da_pkg::STEP_LOAD;
    end else begin
      step_q <= step_d;
    end
  end

endmodule

### hdl/binary_to_decimal_ascii_core.sv
// ----------------------------------------------------------------------------
// Binary to decimal ASCII converter
// Serial double dabble conversion under microcode control, then one ASCII
// digit per output transaction, most significant first, leading zeros dropped.
// ----------------------------------------------------------------------------
//   Channel | Signals                                  | Direction
//   input   | value_i, in_valid_i, in_stall_o          | into the core
//   output  | ascii_digit_o, last_digit_o, out_valid_o | out of the core
//           |   out_stall_i                            |
//
// Each transaction runs one load step, one shift of the BCD register per input
// bit, one step per digit position to skip or emit, and one step that leaves
// the skip step on the first significant digit.
// Output stalls hold the emit step. A new transaction is taken once the last
// digit sits in the output register. Reset empties the output register and
// returns the sequencer to its load step.
module binary_to_decimal_ascii_core #(
  parameter int unsigned VALUE_WIDTH = b2da_pkg::VALUE_WIDTH_DEF,
  parameter int unsigned MAX_DIGITS  = b2da_pkg::MAX_DIGITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic [VALUE_WIDTH-1:0]         value_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  output logic [b2da_pkg::ASCII_W-1:0]   ascii_digit_o,
  output logic                           last_digit_o,
  output logic                           out_valid_o,
  input  logic                           out_stall_i
);

  localparam int unsigned BCD_W = MAX_DIGITS * b2da_pkg::DIGIT_W;
  localparam int unsigned BIT_CNT_W = $clog2(VALUE_WIDTH + 1);
  localparam int unsigned DIG_CNT_W = $clog2(MAX_DIGITS + 1);

  b2da_pkg::status_t status;
  b2da_pkg::ctrl_t   ctrl;

  logic [VALUE_WIDTH-1:0]       val_q, val_d;
  logic [BCD_W-1:0]             bcd_q, bcd_d, bcd_adj;
  logic [BIT_CNT_W-1:0]         bit_cnt_q, bit_cnt_d;
  logic [DIG_CNT_W-1:0]         dig_cnt_q, dig_cnt_d;
  logic [b2da_pkg::DIGIT_W-1:0] top_digit;
  logic                         out_valid_q, out_valid_d;
  logic [b2da_pkg::ASCII_W-1:0] out_digit_q, out_digit_d;
  logic                         out_last_q, out_last_d;

  b2da_seq u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .ctrl_o   (ctrl)
  );

  assign top_digit = bcd_q[BCD_W-1 -: b2da_pkg::DIGIT_W];

  always_comb begin
    status.in_valid    = in_valid_i;
    status.out_free    = !out_valid_q || !out_stall_i;
    status.bits_left   = (bit_cnt_q != BIT_CNT_W'(1));
    status.more_digits = (dig_cnt_q != DIG_CNT_W'(1));
    status.lead_zero   = (top_digit == '0) && (dig_cnt_q != DIG_CNT_W'(1));
  end

  always_comb begin
    for (int i = 0; i < MAX_DIGITS; i++) begin
      if (bcd_q[i*b2da_pkg::DIGIT_W +: b2da_pkg::DIGIT_W] >= b2da_pkg::DABBLE_LIMIT) begin
        bcd_adj[i*b2da_pkg::DIGIT_W +: b2da_pkg::DIGIT_W] =
          bcd_q[i*b2da_pkg::DIGIT_W +: b2da_pkg::DIGIT_W] + b2da_pkg::DABBLE_ADD;
      end else begin
        bcd_adj[i*b2da_pkg::DIGIT_W +: b2da_pkg::DIGIT_W] =
          bcd_q[i*b2da_pkg::DIGIT_W +: b2da_pkg::DIGIT_W];
      end
    end
  end

  always_comb begin
    val_d       = val_q;
    bcd_d       = bcd_q;
    bit_cnt_d   = bit_cnt_q;
    dig_cnt_d   = dig_cnt_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_digit_d = out_digit_q;
    out_last_d  = out_last_q;

    if (ctrl.load) begin
      val_d     = value_i;
      bcd_d     = '0;
      bit_cnt_d = BIT_CNT_W'(VALUE_WIDTH);
      dig_cnt_d = DIG_CNT_W'(MAX_DIGITS);
    end

    if (ctrl.dabble) begin
      bcd_d     = {bcd_adj[BCD_W-2:0], val_q[VALUE_WIDTH-1]};
      val_d     = {val_q[VALUE_WIDTH-2:0], 1'b0};
      bit_cnt_d = bit_cnt_q - 1'b1;
    end

    if (ctrl.skip || ctrl.emit) begin
      bcd_d     = {bcd_q[BCD_W-b2da_pkg::DIGIT_W-1:0], {b2da_pkg::DIGIT_W{1'b0}}};
      dig_cnt_d = dig_cnt_q - 1'b1;
    end

    if (ctrl.emit) begin
      out_valid_d = 1'b1;
      out_digit_d = b2da_pkg::ASCII_ZERO + {2'b00, top_digit};
      out_last_d  = !status.more_digits;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      bit_cnt_q   <= '0;
      dig_cnt_q   <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      bit_cnt_q   <= bit_cnt_d;
      dig_cnt_q   <= dig_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q       <= val_d;
    bcd_q       <= bcd_d;
    out_digit_q <= out_digit_d;
    out_last_q  <= out_last_d;
  end

  assign in_stall_o    = !ctrl.in_ready;
  assign out_valid_o   = out_valid_q;
  assign ascii_digit_o = out_digit_q;
  assign last_digit_o  = out_last_q;

endmodule

### hdl/b2da_checker.sv
// ----------------------------------------------------------------------------
// Converter port checker
// Watches the ports of the converter over time and reports violations.
// ----------------------------------------------------------------------------
`include "binary_to_decimal_ascii_core_macros.svh"

module b2da_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_stall_o,
  input logic [b2da_pkg::ASCII_W-1:0] ascii_digit_o,
  input logic                         last_digit_o,
  input logic                         out_valid_o,
  input logic                         out_stall_i
);

  `B2DA_ASSERT_SAME(a_digit_range, clk_i, rst_ni, out_valid_o,
    (ascii_digit_o >= 6'd48) && (ascii_digit_o <= 6'd57), "Digit is not an ASCII numeral.")

  `B2DA_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && !in_stall_o,
    in_stall_o, "Input was not stalled after a transaction was taken.")

  `B2DA_ASSERT_SAME(a_run_closed, clk_i, rst_ni, in_valid_i && !in_stall_o,
    !out_valid_o || last_digit_o, "New transaction taken while a digit run was open.")

  `B2DA_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i,
    out_valid_o && $stable(ascii_digit_o) && $stable(last_digit_o),
    "Stalled output transaction changed.")

endmodule

bind binary_to_decimal_ascii_core b2da_checker u_b2da_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_stall_o    (in_stall_o),
  .ascii_digit_o (ascii_digit_o),
  .last_digit_o  (last_digit_o),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i)
);
